// ===== rtl/tws_pkg.sv =====
package tws_pkg;

  localparam int MAX_KEEP = 16;
  localparam int TAG_BITS = 10;
  localparam int WEIGHT_W = 32;
  localparam int STAMP_W  = 16;
  localparam int KEEP_W   = 5;
  localparam int SLOT_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int TOTAL_W  = $clog2(MAX_KEEP + 1);
  localparam int CNT_W    = (TOTAL_W > KEEP_W) ? TOTAL_W : KEEP_W;
  localparam int KEY_W    = WEIGHT_W + STAMP_W + SLOT_W;

  localparam logic [STAMP_W-1:0] STAMP_MAX  = {STAMP_W{1'b1}};
  localparam logic [KEEP_W-1:0]  KEEP_RESET = KEEP_W'(16);

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REPLACE,
    OP_SHIFT
  } cell_op_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic                       valid;
    logic signed [WEIGHT_W-1:0] weight;
    logic [STAMP_W-1:0]         stamp;
    logic [SLOT_W-1:0]          slot;
    logic [TAG_BITS-1:0]        tag;
  } entry_t;

  typedef struct packed {
    cell_op_t           op;
    logic [STAMP_W-1:0] stamp;
    logic [SLOT_W-1:0]  slot;
  } seq_ctrl_t;

  // Ascending order: lighter first, then earlier stamp, then lower slot.
  function automatic logic [KEY_W-1:0] sort_key(entry_t e);
    return {~e.weight[WEIGHT_W-1], e.weight[WEIGHT_W-2:0], e.stamp, e.slot};
  endfunction

endpackage

// ===== rtl/top_weight_selection.sv =====
// Hypothesis requests are taken one per cycle while collecting.
// After the final request, kept entries leave one per cycle while out_stall is low,
// from the next cycle on, lightest first; input stalls until the last one is taken
// (at most MAX_KEEP entries are kept).
// Order is kept by the sorted row of cells: one parallel compare per cell.
// Synchronous reset empties the row, zeroes the counters, keep_count = 16.
module top_weight_selection (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tws_pkg::KEEP_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tws_pkg::WEIGHT_W-1:0] weight,
  input  logic [tws_pkg::TAG_BITS-1:0]        tag,
  input  logic                                final_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tws_pkg::WEIGHT_W-1:0] kept_weight,
  output logic [tws_pkg::TAG_BITS-1:0]        kept_tag,
  output logic                                end_of_list
);
  import tws_pkg::*;

  entry_t    entries [MAX_KEEP+1];
  logic      lts     [MAX_KEEP+1];
  entry_t    left_e  [MAX_KEEP];
  logic      left_l  [MAX_KEEP];
  entry_t    new_entry;
  seq_ctrl_t seq;

  assign entries[MAX_KEEP] = '0;
  assign lts[MAX_KEEP]     = 1'b0;

  assign new_entry.valid  = 1'b1;
  assign new_entry.weight = weight;
  assign new_entry.stamp  = seq.stamp;
  assign new_entry.slot   = seq.slot;
  assign new_entry.tag    = tag;

  tws_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .final_item   (final_item),
    .weight       (weight),
    .head         (entries[0]),
    .head_is_last (!entries[1].valid),
    .out_stall    (out_stall),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .seq          (seq)
  );

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_e[i] = '0;
      assign left_l[i] = 1'b1;
    end else begin : g_body
      assign left_e[i] = entries[i-1];
      assign left_l[i] = lts[i-1];
    end

    tws_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (seq.op),
      .new_entry   (new_entry),
      .left_entry  (left_e[i]),
      .left_lt     (left_l[i]),
      .right_entry (entries[i+1]),
      .right_lt    (lts[i+1]),
      .entry       (entries[i]),
      .lt          (lts[i])
    );
  end

  assign kept_weight = entries[0].weight;
  assign kept_tag    = entries[0].tag;
  assign end_of_list = !entries[1].valid;

endmodule

// ===== rtl/tws_cell.sv =====
module tws_cell (
  input  logic             clk,
  input  logic             rst,
  input  tws_pkg::cell_op_t op,
  input  tws_pkg::entry_t  new_entry,
  input  tws_pkg::entry_t  left_entry,
  input  logic             left_lt,
  input  tws_pkg::entry_t  right_entry,
  input  logic             right_lt,
  output tws_pkg::entry_t  entry,
  output logic             lt
);
  import tws_pkg::*;

  entry_t entry_next;

  assign lt = entry.valid && (sort_key(entry) < sort_key(new_entry));

  always_comb begin
    entry_next = entry;
    unique case (op)
      OP_HOLD: begin
        entry_next = entry;
      end
      OP_INSERT: begin
        // cells at or past the insertion point move up by one
        if (!lt) begin
          if (left_lt) begin
            entry_next = new_entry;
          end else begin
            entry_next = left_entry;
          end
        end
      end
      OP_REPLACE: begin
        // head drops out; lighter entries move down, new one lands after them
        if (right_lt) begin
          entry_next = right_entry;
        end else if (lt) begin
          entry_next = new_entry;
        end
      end
      OP_SHIFT: begin
        entry_next = right_entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

// ===== rtl/tws_ctrl.sv =====
module tws_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tws_pkg::KEEP_W-1:0]      cfg_data,
  input  logic                            in_valid,
  input  logic                            final_item,
  input  logic signed [tws_pkg::WEIGHT_W-1:0] weight,
  input  tws_pkg::entry_t                 head,
  input  logic                            head_is_last,
  input  logic                            out_stall,
  output logic                            in_stall,
  output logic                            out_valid,
  output tws_pkg::seq_ctrl_t              seq
);
  import tws_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [KEEP_W-1:0]  keep_count;
  logic [STAMP_W-1:0] arrival;
  logic [TOTAL_W-1:0] total;
  logic               accept;
  logic               fill;
  logic               heavier;

  assign accept  = in_valid && (state == ST_COLLECT);
  assign fill    = (CNT_W'(total) < CNT_W'(MAX_KEEP)) &&
                   ((CNT_W'(total) < CNT_W'(keep_count)) ||
                    ((keep_count == '0) && (total == '0)));
  assign heavier = $signed(weight) > $signed(head.weight);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (accept && final_item) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!out_stall && head_is_last) begin
          state_next = ST_COLLECT;
        end
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b0;
    out_valid = 1'b0;
    seq.op    = OP_HOLD;
    seq.stamp = arrival;
    seq.slot  = fill ? SLOT_W'(total) : head.slot;
    unique case (state)
      ST_COLLECT: begin
        if (accept) begin
          if (fill) begin
            seq.op = OP_INSERT;
          end else if (heavier) begin
            seq.op = OP_REPLACE;
          end
        end
      end
      ST_DRAIN: begin
        in_stall  = 1'b1;
        out_valid = 1'b1;
        if (!out_stall) begin
          seq.op = OP_SHIFT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      keep_count <= KEEP_RESET;
      arrival    <= '0;
      total      <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        keep_count <= cfg_data;
      end
      if (accept) begin
        if (final_item) begin
          arrival <= '0;
          total   <= '0;
        end else begin
          if (arrival != STAMP_MAX) begin
            arrival <= arrival + 1'b1;
          end
          if (fill) begin
            total <= total + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/tws_checker.sv =====
module tws_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                final_item,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [tws_pkg::WEIGHT_W-1:0] kept_weight,
  input logic [tws_pkg::TAG_BITS-1:0]        kept_tag,
  input logic                                end_of_list
);
  import tws_pkg::*;

  // no new request while results are going out
  a_stall_in_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  // a request without the final mark produces nothing
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !final_item) |=> !out_valid)
    else $error("result after non-final request");

  // results come out back to back in ascending weight
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !end_of_list) |=>
      (out_valid && ($signed(kept_weight) >= $signed($past(kept_weight)))))
    else $error("results out of order");

  // the flagged last result closes the list and reopens the input
  a_list_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && end_of_list) |=> (!out_valid && !in_stall))
    else $error("list did not close");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(kept_weight) && $stable(kept_tag) && $stable(end_of_list)))
    else $error("stalled result changed");

endmodule

bind top_weight_selection tws_checker u_tws_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tws_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = MAX_KEEP + 4;
  localparam int RANDOM_ITEMS = 240;
  localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};
  localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [TAG_BITS-1:0] TAG_TOP = {TAG_BITS{1'b1}};

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [TAG_BITS-1:0]        tag;
    logic                       eol;
  } kept_rec_t;

  // Tracks the kept store and queues the sorted entries each final request releases.
  class topk_tracker;
    logic signed [WEIGHT_W-1:0] w_slot[MAX_KEEP];
    logic [TAG_BITS-1:0]        t_slot[MAX_KEEP];
    logic [STAMP_W-1:0]         s_slot[MAX_KEEP];
    int                         fill;
    logic [STAMP_W-1:0]         stamp_next;
    logic [KEEP_W-1:0]          keep_count;
    kept_rec_t                  kept_due[$];
    int                         errors;
    int                         checked;
    int                         runs;

    function new();
      fill = 0;
      stamp_next = '0;
      keep_count = KEEP_RESET;
      errors = 0;
      checked = 0;
      runs = 0;
    endfunction

    // lighter, or equal weight and earlier stamp, or lower slot
    function bit lighter(int a, int b);
      if (w_slot[a] != w_slot[b]) return w_slot[a] < w_slot[b];
      if (s_slot[a] != s_slot[b]) return s_slot[a] < s_slot[b];
      return a < b;
    endfunction

    function void note_request(logic signed [WEIGHT_W-1:0] w, logic [TAG_BITS-1:0] t,
                               logic f);
      int limit;
      int low;
      int best;
      int n;
      bit used[MAX_KEEP];
      kept_rec_t rec;
      limit = (keep_count == 0) ? 1 : (keep_count > MAX_KEEP) ? MAX_KEEP : int'(keep_count);
      if (fill < limit) begin
        w_slot[fill] = w;
        t_slot[fill] = t;
        s_slot[fill] = stamp_next;
        fill++;
      end else if (fill > 0) begin
        low = 0;
        for (int i = 1; i < fill; i++)
          if (lighter(i, low)) low = i;
        if (w > w_slot[low]) begin
          w_slot[low] = w;
          t_slot[low] = t;
          s_slot[low] = stamp_next;
        end
      end
      if (stamp_next != STAMP_MAX) stamp_next++;
      if (!f) return;
      n = fill;
      for (int i = 0; i < MAX_KEEP; i++) used[i] = 1'b0;
      for (int k = 0; k < n; k++) begin
        best = -1;
        for (int i = 0; i < n; i++)
          if (!used[i] && (best < 0 || lighter(i, best))) best = i;
        used[best] = 1'b1;
        rec.weight = w_slot[best];
        rec.tag = t_slot[best];
        rec.eol = (k == n - 1);
        kept_due = {kept_due, rec};
      end
      fill = 0;
      stamp_next = '0;
      runs++;
    endfunction

    function void check_kept(logic signed [WEIGHT_W-1:0] w, logic [TAG_BITS-1:0] t,
                             logic e);
      kept_rec_t rec;
      checked++;
      if (kept_due.size() == 0) begin
        $error("unexpected kept entry: weight %0d tag %0d end_of_list %0b", w, t, e);
        errors++;
        return;
      end
      rec = kept_due.pop_front();
      if (w !== rec.weight) begin
        $error("kept_weight mismatch: expected %0d, got %0d", rec.weight, w);
        errors++;
      end
      if (t !== rec.tag) begin
        $error("kept_tag mismatch: expected %0d, got %0d", rec.tag, t);
        errors++;
      end
      if (e !== rec.eol) begin
        $error("end_of_list mismatch: expected %0b, got %0b", rec.eol, e);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [KEEP_W-1:0]          cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [WEIGHT_W-1:0] weight;
  logic [TAG_BITS-1:0]        tag;
  logic                       final_item;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [WEIGHT_W-1:0] kept_weight;
  logic [TAG_BITS-1:0]        kept_tag;
  logic                       end_of_list;

  topk_tracker                tracker;
  int                         cycle_count;
  int                         items_sent;
  int                         cfg_writes;
  int                         hold_request;
  bit                         quiet;
  logic signed [WEIGHT_W-1:0] recent_weight;

  top_weight_selection u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .weight      (weight),
    .tag         (tag),
    .final_item  (final_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kept_weight (kept_weight),
    .kept_tag    (kept_tag),
    .end_of_list (end_of_list)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: random stall bursts, plus a long hold when one is requested.
  initial begin
    int hold_left;
    int burst_left;
    bit burst_stall;
    hold_left = 0;
    burst_left = 0;
    burst_stall = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall = 1'b0;
        burst_left = 0;
      end else begin
        if (burst_left == 0) begin
          burst_stall = ($urandom_range(0, 2) == 0);
          if (!burst_stall) burst_left = $urandom_range(1, 20);
          else if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(15, 50);
          else burst_left = $urandom_range(1, 3);
        end
        out_stall = burst_stall;
        burst_left--;
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) tracker.check_kept(kept_weight, kept_tag, end_of_list);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    logic signed [WEIGHT_W-1:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: w = $signed($urandom);
      4, 5, 6:    w = WEIGHT_W'(int'($urandom_range(0, 16)) - 8);
      7:          w = recent_weight;
      8: begin
        case ($urandom_range(0, 3))
          0:       w = W_MIN;
          1:       w = W_MAX;
          2:       w = '0;
          default: w = '1;
        endcase
      end
      default:    w = W_MIN + WEIGHT_W'($urandom_range(0, 7));
    endcase
    recent_weight = w;
    return w;
  endfunction

  // Offer one request, hold it until taken, then idle for a random gap.
  task automatic send_request(input logic signed [WEIGHT_W-1:0] w,
                              input logic [TAG_BITS-1:0] t, input logic f);
    int gap;
    @(negedge clk);
    weight = w;
    tag = t;
    final_item = f;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    tracker.note_request(w, t, f);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.kept_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_keep_count(input logic [KEEP_W-1:0] v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
    tracker.keep_count = v;
    cfg_writes++;
  endtask

  initial begin
    int run_len;
    int rand_items;
    bit run_open;
    logic [KEEP_W-1:0] k;
    tracker = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    weight = '0;
    tag = '0;
    final_item = 1'b0;
    items_sent = 0;
    cfg_writes = 0;
    hold_request = 0;
    quiet = 1'b0;
    recent_weight = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Extremes and ties with the reset keep count, fewer items than kept.
    send_request(W_MIN, '0, 1'b0);
    send_request(W_MAX, TAG_TOP, 1'b0);
    send_request('0, 10'h2AA, 1'b0);
    send_request('1, 10'h155, 1'b0);
    send_request(32'sh0001_0000, 10'd1, 1'b0);
    send_request(32'sh0001_0000, 10'd2, 1'b0);
    send_request(32'sh0001_0000, 10'd3, 1'b0);
    send_request(W_MIN, 10'd4, 1'b0);
    send_request(32'sh0000_0001, 10'd5, 1'b0);
    send_request(W_MAX, 10'd6, 1'b1);
    wait_idle();

    // Zero keep count acts as one; an equal weight does not displace.
    set_keep_count('0);
    send_request(32'sd7, 10'd11, 1'b0);
    send_request(32'sd7, 10'd12, 1'b0);
    send_request(32'sd9, 10'd13, 1'b0);
    send_request(32'sd3, 10'd14, 1'b1);
    wait_idle();

    // Equal lightest entries: the earliest goes first.
    set_keep_count(5'd3);
    send_request(-32'sd5, 10'd21, 1'b0);
    send_request(-32'sd5, 10'd22, 1'b0);
    send_request(-32'sd5, 10'd23, 1'b0);
    send_request(-32'sd4, 10'd24, 1'b0);
    send_request(-32'sd4, 10'd25, 1'b1);
    wait_idle();

    // Lower the keep count in the middle of a run.
    set_keep_count(5'd8);
    for (int i = 0; i < 6; i++) send_request(32'(10 * (i + 1)), 10'(30 + i), 1'b0);
    wait_idle();
    set_keep_count(5'd2);
    send_request(32'sd5, 10'd40, 1'b0);
    send_request(32'sd70, 10'd41, 1'b1);
    wait_idle();

    // Full store of equal weights; heavier requests push out the earliest.
    set_keep_count(5'd16);
    quiet = 1'b1;
    for (int i = 0; i < MAX_KEEP; i++) send_request(32'sd100, 10'(600 + i), 1'b0);
    for (int i = 0; i < 3; i++) send_request(32'sd101, 10'(700 + i), 1'b0);
    send_request(32'sd100, 10'd710, 1'b1);
    wait_idle();

    // Hold the output long enough that the input backs up.
    hold_request = 300;
    for (int r = 0; r < 3; r++)
      for (int i = 0; i < 10; i++) send_request(pick_weight(), 10'($urandom), i == 9);
    quiet = 1'b0;
    wait_idle();

    rand_items = 0;
    run_open = 1'b0;
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       k = '0;
          1:       k = 5'd1;
          2:       k = 5'd16;
          3:       k = '1;
          4:       k = 5'($urandom_range(17, 31));
          default: k = 5'($urandom_range(2, 8));
        endcase
        set_keep_count(k);
      end
      quiet = ($urandom_range(0, 3) == 0);
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 20);
      run_open = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < run_len; i++)
        send_request(pick_weight(), 10'($urandom), !run_open && i == run_len - 1);
      rand_items += run_len;
      wait_idle();
    end
    quiet = 1'b0;
    if (run_open) send_request(pick_weight(), 10'($urandom), 1'b1);
    wait_idle();

    $display("Sent %0d requests in %0d closed runs, %0d kept entries, %0d keep_count writes",
             items_sent, tracker.runs, tracker.checked, cfg_writes);
    $display("including extreme and tied weights, keep counts 0/1/16/31, a long output hold");
    if (tracker.errors == 0 && tracker.kept_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tws_pkg.sv
rtl/tws_cell.sv
rtl/tws_ctrl.sv
rtl/top_weight_selection.sv
rtl/tws_checker.sv
dv/tb_top.sv
